@@ design/status_record_checker_assert.svh @@
// Assertion helpers used by the bound checker module.
`ifndef STATUS_RECORD_CHECKER_ASSERT_SVH
`define STATUS_RECORD_CHECKER_ASSERT_SVH

// Implication checked only while reset is released.
`define SRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked only while reset is released.
`define SRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked at every edge, reset included.
`define SRC_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/statrec_pkg.sv @@
`timescale 1ns / 1ps

package statrec_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned AGE_W   = 32;
  // 32-bit milliseconds times 1e6 needs 52 bits.
  localparam int unsigned LIMIT_W = 52;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [AGE_W-1:0]   DEFAULT_MAX_AGE_MS = 32'd1000;
  localparam logic [31:0]        REC_MAGIC          = 32'h5652_5443;
  localparam logic [31:0]        REC_VERSION        = 32'd1;
  localparam logic [31:0]        REC_SIZE           = 32'd40;
  localparam logic [HASH_W-1:0]  HASH_OFFSET        = 32'd2166136261;
  localparam logic [HASH_W-1:0]  HASH_PRIME         = 32'd16777619;
  localparam logic [19:0]        NS_PER_MS          = 20'd1000000;

  // Byte positions inside the record.
  localparam logic [POS_W-1:0] POS_MAGIC     = 6'd3;
  localparam logic [POS_W-1:0] POS_VERSION   = 6'd7;
  localparam logic [POS_W-1:0] POS_SIZE      = 6'd11;
  localparam logic [POS_W-1:0] POS_VALID     = 6'd15;
  localparam logic [POS_W-1:0] POS_ACTIVE    = 6'd19;
  localparam logic [POS_W-1:0] POS_HASH_LAST = 6'd31;
  localparam logic [POS_W-1:0] POS_LAST      = 6'd39;

  typedef enum logic [2:0] {
    FAULT_OK      = 3'd0,
    FAULT_MAGIC   = 3'd1,
    FAULT_VERSION = 3'd2,
    FAULT_SIZE    = 3'd3,
    FAULT_HASH    = 3'd4,
    FAULT_INVALID = 3'd5,
    FAULT_TIME    = 3'd6,
    FAULT_STALE   = 3'd7
  } fault_t;

  typedef struct packed {
    logic magic;
    logic version;
    logic size;
  } hdr_flags_t;

endpackage

@@ design/status_record_checker.sv @@
`timescale 1ns / 1ps

// Checks 40-byte little-endian status records streamed one byte per request, with
// tuser[0] marking byte 0. An FNV-1a hash runs over bytes 0..31 and the header,
// valid word, timestamp and stored hash are checked; one result leaves on the
// master side after byte 39 passes the input register and the result register.
// The block takes one byte every cycle unless a result is stalled on the master
// side; the path that sets the clock is the per-byte hash multiply by the FNV
// prime feeding the running hash register, and on byte 39 the 64-bit age
// subtract and compare against the limit. A marked first byte drops any partial
// record, and unmarked bytes outside a record are discarded. cfg_wr_data sets the
// maximum age in ms (zero selects 1000 ms); the ns limit is registered from it.
module status_record_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [statrec_pkg::AGE_W-1:0]        cfg_wr_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [7:0] data_byte, [71:8] now_ns
  input  logic [statrec_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] first_byte
  input  logic [0:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] record_ok, [1] active_flag, [4:2] fault_code, [7:5] zero
  output logic [statrec_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import statrec_pkg::*;

  logic [AGE_W-1:0]   max_age_r;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [AGE_W-1:0]   eff_age;

  logic               in_valid_r;
  logic [DATA_W-1:0]  in_byte_r;
  logic               in_first_r;
  logic [TIME_W-1:0]  in_now_r;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [63:0]        word_r, word_nxt;
  hdr_flags_t         flags_r, flags_nxt;
  logic               valid_nz_r, valid_nz_nxt;
  logic               active_nz_r, active_nz_nxt;
  logic [TIME_W-1:0]  stamp_r, stamp_nxt;
  logic [HASH_W-1:0]  comp_hash_r, comp_hash_nxt;

  logic               out_valid_r;
  logic [4:0]         out_data_r;

  logic [POS_W-1:0]   cur_pos;
  logic [2:0]         slot;
  logic               ignore;
  logic               has_result;
  logic               proc;
  logic               out_free;
  logic [HASH_W-1:0]  hash_base;
  logic [HASH_W-1:0]  hash_mix;
  logic [TIME_W-1:0]  age;
  fault_t             fault;

  // The ns limit follows the maximum-age register in the cycle after it changes.
  always_comb begin
    eff_age   = (max_age_r != '0) ? max_age_r : DEFAULT_MAX_AGE_MS;
    limit_nxt = LIMIT_W'(eff_age) * LIMIT_W'(NS_PER_MS);
  end

  always_comb begin
    cur_pos    = in_first_r ? '0 : pos_r;
    slot       = cur_pos[2:0];
    ignore     = !in_first_r && (pos_r == '0);
    has_result = in_valid_r && !ignore && (cur_pos == POS_LAST);
    out_free   = !out_valid_r || out_tready;
    proc       = in_valid_r && (!has_result || out_free);
    in_tready  = !in_valid_r || proc;
  end

  always_comb begin
    hash_base = in_first_r ? HASH_OFFSET : hash_r;
    hash_mix  = hash_base ^ HASH_W'(in_byte_r);
    hash_nxt  = (cur_pos <= POS_HASH_LAST) ? HASH_W'(hash_mix * HASH_PRIME) : hash_base;

    for (int i = 0; i < 8; i++) begin
      if (slot == 3'(i)) begin
        word_nxt[8*i +: 8] = in_byte_r;
      end else if (slot == 3'd0) begin
        word_nxt[8*i +: 8] = 8'd0;
      end else begin
        word_nxt[8*i +: 8] = word_r[8*i +: 8];
      end
    end

    flags_nxt     = in_first_r ? '0 : flags_r;
    valid_nz_nxt  = valid_nz_r;
    active_nz_nxt = active_nz_r;
    stamp_nxt     = stamp_r;
    comp_hash_nxt = comp_hash_r;
    unique case (cur_pos)
      POS_MAGIC:     flags_nxt.magic   = flags_nxt.magic   || (word_nxt[31:0] == REC_MAGIC);
      POS_VERSION:   flags_nxt.version = flags_nxt.version || (word_nxt[63:32] == REC_VERSION);
      POS_SIZE:      flags_nxt.size    = flags_nxt.size    || (word_nxt[31:0] == REC_SIZE);
      POS_VALID:     valid_nz_nxt  = (word_nxt[63:32] != '0);
      POS_ACTIVE:    active_nz_nxt = (word_nxt[31:0] != '0);
      POS_HASH_LAST: begin
        stamp_nxt     = word_nxt;
        comp_hash_nxt = hash_nxt;
      end
      default: ;
    endcase

    if (ignore) begin
      pos_nxt = pos_r;
    end else if (cur_pos == POS_LAST) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = cur_pos + POS_W'(1);
    end
  end

  // Record checks in their fixed order; the first one that fails is reported.
  always_comb begin
    age = in_now_r - stamp_r;
    priority if (!flags_r.magic) begin
      fault = FAULT_MAGIC;
    end else if (!flags_r.version) begin
      fault = FAULT_VERSION;
    end else if (!flags_r.size) begin
      fault = FAULT_SIZE;
    end else if (word_nxt[31:0] != comp_hash_r) begin
      fault = FAULT_HASH;
    end else if (!valid_nz_r) begin
      fault = FAULT_INVALID;
    end else if (in_now_r == '0 || stamp_r == '0 || in_now_r < stamp_r) begin
      fault = FAULT_TIME;
    end else if (age > TIME_W'(limit_r)) begin
      fault = FAULT_STALE;
    end else begin
      fault = FAULT_OK;
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    if (!rst_n) begin
      max_age_r   <= '0;
      in_valid_r  <= 1'b0;
      pos_r       <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_age_r <= cfg_wr_data;
      end

      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (proc) begin
        in_valid_r <= 1'b0;
      end

      if (proc) begin
        pos_r   <= pos_nxt;
        flags_r <= flags_nxt;
      end

      if (proc && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata[7:0];
      in_first_r <= in_tuser[0];
      in_now_r   <= in_tdata[71:8];
    end
    if (proc) begin
      hash_r      <= hash_nxt;
      word_r      <= word_nxt;
      valid_nz_r  <= valid_nz_nxt;
      active_nz_r <= active_nz_nxt;
      stamp_r     <= stamp_nxt;
      comp_hash_r <= comp_hash_nxt;
    end
    if (proc && has_result) begin
      out_data_r <= {fault, (fault == FAULT_OK) && active_nz_r, fault == FAULT_OK};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

endmodule

@@ design/statrec_checker.sv @@
`timescale 1ns / 1ps
`include "status_record_checker_assert.svh"

module statrec_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_wr_en,
  input logic [statrec_pkg::AGE_W-1:0]       cfg_wr_data,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [statrec_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [0:0]                          in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [statrec_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import statrec_pkg::*;

  logic result_ok;
  logic cfg_seen;
  logic in_seen;

  assign result_ok = (out_tdata[4:2] == FAULT_OK);
  assign cfg_seen  = cfg_wr_en && (cfg_wr_data == cfg_wr_data);
  assign in_seen   = in_tvalid && in_tready && (in_tuser == in_tuser) && (in_tdata == in_tdata);

  // A stalled result stays put.
  `SRC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata), "result changed while stalled")
  // The pass bit agrees with the fault code.
  `SRC_ASSERT_IMP(a_ok_code, out_tvalid, out_tdata[0] == result_ok,
                  "record_ok disagrees with fault_code")
  // The active flag is only reported on an accepted record.
  `SRC_ASSERT_IMP(a_active_ok, out_tvalid && out_tdata[1], out_tdata[0],
                  "active_flag set on a rejected record")
  // No result may appear straight out of reset.
  `SRC_ASSERT_ALWAYS(a_rst_quiet, $past(!rst_n) && !(cfg_seen && in_seen), !out_tvalid,
                     "result valid right after reset")

endmodule

bind status_record_checker statrec_checker u_statrec_checker (.*);

@@ tb/record_verdict_monitor.sv @@
`timescale 1ns / 1ps

module record_verdict_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [statrec_pkg::AGE_W-1:0] cfg_wr_data,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // [7:0] data_byte, [71:8] now_ns
  input  logic [statrec_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] first_byte
  input  logic [0:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] record_ok, [1] active_flag, [4:2] fault_code, [7:5] zero
  input  logic [statrec_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                            fail_count,
  output int                            open_count
);
  import statrec_pkg::*;

  typedef struct packed {
    fault_t fault;
    logic   active;
    logic   ok;
  } verdict_t;

  verdict_t         verdict_q[$];
  logic [AGE_W-1:0] age_limit_ms;
  logic [POS_W-1:0] rec_pos;
  logic [31:0]      fnv_acc;
  logic [63:0]      word_acc;
  hdr_flags_t       hdr_seen;
  logic             valid_seen;
  logic             active_seen;
  logic [63:0]      rec_stamp;
  logic [31:0]      rec_hash;

  initial fail_count = 0;

  function automatic void clear_record();
    rec_pos     = '0;
    fnv_acc     = HASH_OFFSET;
    word_acc    = '0;
    hdr_seen    = '0;
    valid_seen  = 1'b0;
    active_seen = 1'b0;
    rec_stamp   = '0;
    rec_hash    = '0;
  endfunction

  // The first failing check wins: magic, version, size, hash, valid word, time, then age.
  function automatic fault_t grade_record(input logic [63:0] now);
    logic [63:0] limit_ns;
    if (!hdr_seen.magic) return FAULT_MAGIC;
    if (!hdr_seen.version) return FAULT_VERSION;
    if (!hdr_seen.size) return FAULT_SIZE;
    if (word_acc[31:0] != rec_hash) return FAULT_HASH;
    if (!valid_seen) return FAULT_INVALID;
    if (now == 64'd0 || rec_stamp == 64'd0 || now < rec_stamp) return FAULT_TIME;
    limit_ns = 64'(age_limit_ms == '0 ? DEFAULT_MAX_AGE_MS : age_limit_ms) * 64'd1000000;
    if (now - rec_stamp > limit_ns) return FAULT_STALE;
    return FAULT_OK;
  endfunction

  task automatic absorb_byte(input logic [7:0] value, input logic first,
                             input logic [63:0] now);
    logic [POS_W-1:0] pos;
    verdict_t         v;
    if (first) begin
      clear_record();
    end else if (rec_pos == '0) begin
      return;
    end
    pos = rec_pos;
    if (pos <= POS_HASH_LAST) fnv_acc = (fnv_acc ^ {24'h0, value}) * HASH_PRIME;
    if (pos[2:0] == 3'd0) word_acc = '0;
    word_acc[8*pos[2:0] +: 8] = value;
    case (pos)
      POS_MAGIC: begin
        if (word_acc[31:0] == REC_MAGIC) hdr_seen.magic = 1'b1;
      end
      POS_VERSION: begin
        if (word_acc[63:32] == REC_VERSION) hdr_seen.version = 1'b1;
      end
      POS_SIZE: begin
        if (word_acc[31:0] == REC_SIZE) hdr_seen.size = 1'b1;
      end
      POS_VALID: valid_seen = (word_acc[63:32] != 32'd0);
      POS_ACTIVE: active_seen = (word_acc[31:0] != 32'd0);
      POS_HASH_LAST: begin
        rec_stamp = word_acc;
        rec_hash  = fnv_acc;
      end
      default: ;
    endcase
    if (pos == POS_LAST) begin
      v.fault = grade_record(now);
      v.ok = (v.fault == FAULT_OK);
      v.active = v.ok && active_seen;
      verdict_q.push_back(v);
      rec_pos = '0;
    end else begin
      rec_pos = pos + 6'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_verdict(input logic [7:0] bus);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch("result with none pending", bus, 8'h0);
      return;
    end
    want = verdict_q.pop_front();
    if (bus[0] !== want.ok) report_mismatch("record_ok", 8'(bus[0]), 8'(want.ok));
    if (bus[1] !== want.active) report_mismatch("active_flag", 8'(bus[1]), 8'(want.active));
    if (bus[4:2] !== want.fault) report_mismatch("fault_code", 8'(bus[4:2]), 8'(want.fault));
    if (bus[7:5] !== 3'b000) report_mismatch("pad bits", 8'(bus[7:5]), 8'h0);
  endtask

  // Results only leave after the closing byte passes the input and result registers,
  // so checking the output before taking the input request on the same edge is safe.
  always @(posedge clk) begin
    if (!rst_n) begin
      age_limit_ms = '0;
      clear_record();
      verdict_q.delete();
    end else begin
      if (cfg_wr_en) age_limit_ms = cfg_wr_data;
      if (out_tvalid && out_tready) check_verdict(out_tdata);
      if (in_tvalid && in_tready) absorb_byte(in_tdata[7:0], in_tuser[0], in_tdata[71:8]);
    end
    open_count = verdict_q.size();
  end

endmodule

@@ tb/status_record_checker_test.sv @@
`timescale 1ns / 1ps

module status_record_checker_test;
  import statrec_pkg::*;

  typedef struct {
    logic [31:0] magic;
    logic [31:0] version;
    logic [31:0] size_w;
    logic [31:0] valid_w;
    logic [31:0] active_w;
    logic [31:0] spare_a;
    logic [63:0] stamp;
    logic [31:0] hash_flip;
    logic [31:0] spare_b;
  } status_rec_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [AGE_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;
  int                     open_count;

  logic [AGE_W-1:0] age_cfg = '0;
  int               send_gap_odds = 0;
  int               take_gap_odds = 0;
  bit               hold_request = 1'b0;

  status_record_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  record_verdict_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request so
  // that the block backs up and stops taking bytes.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_request = 1'b0;
      end else if (take_gap_odds != 0 && $urandom_range(1, 100) <= take_gap_odds) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] age_limit_ns();
    return 64'(age_cfg == '0 ? DEFAULT_MAX_AGE_MS : age_cfg) * 64'd1000000;
  endfunction

  function automatic status_rec_t sound_record(input logic [63:0] stamp);
    status_rec_t r;
    r.magic     = REC_MAGIC;
    r.version   = REC_VERSION;
    r.size_w    = REC_SIZE;
    r.valid_w   = $urandom;
    if (r.valid_w == 32'd0) r.valid_w = 32'd1;
    r.active_w  = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
    r.spare_a   = $urandom;
    r.stamp     = stamp;
    r.hash_flip = 32'd0;
    r.spare_b   = $urandom;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic first,
                           input logic [63:0] now);
    if (send_gap_odds != 0 && $urandom_range(1, 100) <= send_gap_odds) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, value};
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Sends the first count bytes of the record; the stored hash is correct
  // unless hash_flip says otherwise.
  task automatic send_record(input status_rec_t r, input logic [63:0] now, input int count);
    logic [319:0] img;
    logic [31:0]  h;
    img = {r.spare_b, 32'h0, r.stamp, r.spare_a, r.active_w, r.valid_w, r.size_w,
           r.version, r.magic};
    h = HASH_OFFSET;
    for (int i = 0; i < 32; i++) h = (h ^ {24'h0, img[8*i +: 8]}) * HASH_PRIME;
    img[287:256] = h ^ r.hash_flip;
    for (int i = 0; i < count; i++)
      send_byte(img[8*i +: 8], i == 0, (i == 39) ? now : rand64());
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_age(input logic [AGE_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    age_cfg = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic random_traffic(input int records);
    status_rec_t r;
    logic [63:0] lim;
    logic [63:0] stamp;
    logic [63:0] now;
    repeat (records) begin
      // Some noise first: stray bytes while idle, or a record cut short.
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, rand64());
        1: send_record(sound_record(rand64()), rand64(), $urandom_range(1, 39));
        default: ;
      endcase
      lim = age_limit_ns();
      stamp = rand64() >> $urandom_range(1, 12);
      if (stamp == 64'd0) stamp = 64'd1;
      r = sound_record(stamp);
      case ($urandom_range(0, 11))
        0: r.magic = r.magic ^ (32'd1 << $urandom_range(0, 31));
        1: r.version = $urandom;
        2: r.size_w = $urandom_range(0, 80);
        3: r.hash_flip = 32'd1 << $urandom_range(0, 31);
        4: r.valid_w = 32'd0;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0: now = 64'd0;
        1: begin
          r.stamp = 64'd0;
          now = rand64();
        end
        2: now = stamp - $urandom_range(1, 1000);
        3: now = stamp + lim;
        4: now = stamp + lim + 64'd1;
        5: now = stamp + lim + (rand64() >> $urandom_range(8, 40));
        6: now = rand64();
        default: now = stamp + rand64() % (lim + 64'd1);
      endcase
      send_record(r, now, 40);
    end
  endtask

  initial begin
    status_rec_t r;
    logic [63:0] st;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_odds = 15;
    take_gap_odds = 15;

    // Directed records under the default age limit.
    st = 64'h0000_0100_0000_0000;
    r = sound_record(st);
    r.active_w = 32'h8000_0000;
    send_record(r, st + 64'd5, 40);
    r.active_w = 32'd0;
    send_record(r, st + age_limit_ns(), 40);
    r = sound_record(st);
    send_record(r, st + age_limit_ns() + 64'd1, 40);
    // A bad magic is reported ahead of a bad hash.
    r.magic = REC_MAGIC ^ 32'h1;
    r.hash_flip = 32'h1;
    send_record(r, st, 40);
    r = sound_record(st);
    r.version = 32'd2;
    send_record(r, st, 40);
    r = sound_record(st);
    r.size_w = 32'd0;
    send_record(r, st, 40);
    r = sound_record(st);
    r.hash_flip = 32'h8000_0000;
    send_record(r, st, 40);
    r = sound_record(st);
    r.valid_w = 32'd0;
    send_record(r, 64'd0, 40);
    r = sound_record(st);
    send_record(r, 64'd0, 40);
    r.stamp = 64'd0;
    send_record(r, 64'd5, 40);
    r = sound_record(st);
    send_record(r, st - 64'd1, 40);
    r = sound_record(64'hFFFF_FFFF_FFFF_FFFF - age_limit_ns());
    send_record(r, 64'hFFFF_FFFF_FFFF_FFFF, 40);
    r = sound_record(64'd1);
    send_record(r, 64'hFFFF_FFFF_FFFF_FFFF, 40);
    r.magic = '1;
    r.version = '1;
    r.size_w = '1;
    r.valid_w = '1;
    r.active_w = '1;
    r.spare_a = '1;
    r.stamp = '1;
    r.spare_b = '1;
    send_record(r, 64'hFFFF_FFFF_FFFF_FFFF, 40);
    // A marked byte in the middle of a record, and on its very last position,
    // drops what came before it.
    r = sound_record(st);
    send_record(r, rand64(), 17);
    send_record(r, st + 64'd1, 40);
    send_record(r, rand64(), 39);
    send_record(r, st + 64'd2, 40);
    repeat (3) send_byte(8'($urandom), 1'b0, rand64());
    send_record(r, st + 64'd3, 40);

    write_max_age(32'd1);
    random_traffic(2);
    write_max_age(32'hFFFF_FFFF);
    send_gap_odds = 40;
    take_gap_odds = 5;
    random_traffic(2);
    write_max_age(32'd0);
    send_gap_odds = 0;
    hold_request = 1'b1;
    random_traffic(3);
    write_max_age($urandom);
    send_gap_odds = 15;
    take_gap_odds = 30;
    random_traffic(1);
    settle();
    random_traffic(1);
    // Closing stretch runs at full rate on both sides.
    write_max_age(32'd1000);
    send_gap_odds = 0;
    take_gap_odds = 0;
    random_traffic(4);
    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
